// ----- rtl/pcd_pkg.sv -----
// Shared types, constants and helper functions for the prefix code table decoder.
// Used by pcd_code_store and prefix_code_table_decoder_unit; depends on nothing.
`default_nettype none

package pcd_pkg;

	localparam int TABLE_DEPTH  = 256;
	localparam int MAX_CODE_LEN = 32;

	localparam int ADDR_W   = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CODE_W   = 32;
	localparam int LEN_W    = 6;
	localparam int SYM_W    = 8;
	localparam int TCOUNT_W = 9;
	localparam int CNT_W    = 6;
	localparam int COUNT_LIMIT = (MAX_CODE_LEN < 63) ? MAX_CODE_LEN : 63;

	localparam logic [TCOUNT_W-1:0] DEPTH_COUNT = TCOUNT_W'(TABLE_DEPTH);
	localparam logic [CNT_W-1:0]    LIMIT_COUNT = CNT_W'(COUNT_LIMIT);
	localparam logic [2:0]          PAD_MAX     = 3'd7;

	localparam logic [1:0] KIND_ENTRY   = 2'd0;
	localparam logic [1:0] KIND_HEADER  = 2'd1;
	localparam logic [1:0] KIND_PAYLOAD = 2'd2;

	localparam logic [1:0] RES_SYMBOL    = 2'd0;
	localparam logic [1:0] RES_FRAME_END = 2'd1;
	localparam logic [1:0] RES_OVERFLOW  = 2'd2;

	typedef struct packed {
		logic [1:0]  kind;
		logic [7:0]  entry_index;
		logic [31:0] entry_code;
		logic [5:0]  entry_length;
		logic [7:0]  entry_symbol;
		logic [7:0]  data_byte;
		logic        last_byte;
	} item_t;

	typedef struct packed {
		logic [1:0] result_type;
		logic [7:0] symbol;
		logic [5:0] leftover_bits;
		logic       run_last;
	} result_t;

	typedef struct packed {
		logic [CODE_W-1:0] code;
		logic [LEN_W-1:0]  length;
		logic [SYM_W-1:0]  symbol;
	} entry_t;

	typedef struct packed {
		logic              en;
		logic [ADDR_W-1:0] addr;
		entry_t            entry;
	} store_wr_t;

	typedef struct packed {
		logic              en;
		logic [ADDR_W-1:0] addr;
	} store_rd_t;

	typedef struct packed {
		logic             hit;
		logic [SYM_W-1:0] symbol;
	} store_hit_t;

	function automatic logic [CODE_W-1:0] len_mask(input logic [CNT_W-1:0] len);
		logic [CODE_W-1:0] m;
		if (len >= CNT_W'(CODE_W)) begin
			m = '1;
		end else begin
			m = ~({CODE_W{1'b1}} << len);
		end
		return m;
	endfunction

endpackage

`default_nettype wire

// ----- rtl/pcd_code_store.sv -----
// Code table memory with one write port and one registered read port, plus the
// match compare of the read entry against the accumulated code. Uses pcd_pkg.
`default_nettype none

module pcd_code_store (
	input  wire                         clk,
	input  pcd_pkg::store_wr_t          wr,
	input  pcd_pkg::store_rd_t          rd,
	input  wire [pcd_pkg::CODE_W-1:0]   code,
	input  wire [pcd_pkg::CNT_W-1:0]    count,
	output pcd_pkg::store_hit_t         hit
);

	pcd_pkg::entry_t mem [pcd_pkg::TABLE_DEPTH];
	pcd_pkg::entry_t rd_q;

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.entry;
		end
		if (rd.en) begin
			rd_q <= mem[rd.addr];
		end
	end

	always_comb begin
		hit.symbol = rd_q.symbol;
		hit.hit    = (rd_q.length != '0) && (rd_q.length == count) &&
			(((code ^ rd_q.code) & pcd_pkg::len_mask(count)) == '0);
	end

endmodule

`default_nettype wire

// ----- rtl/prefix_code_table_decoder_unit.sv -----
// Top level of the prefix code table decoder: control sequencer, bit accumulator,
// result holding and output registers. Uses pcd_pkg and pcd_code_store.
//
// Usage: the item channel (item_valid, item_stall, item) carries table entry
// writes, frame header bytes and payload bytes. A transaction takes place at a
// rising edge where valid is high and stall is low. The result channel
// (result_valid, result_stall, result) delivers decoded symbols, overflow
// results and frame-end results; run_last marks the final result of an item.
// cfg_we with cfg_wdata writes the search count, which is to be changed only
// while the block is idle. An entry write or a header not marked last is handled in
// the idle state; a header marked last passes through the push and final states.
// For each payload bit the table search tests up to n entries, n = min(search
// count, 256), and reads one entry per cycle from the single read port of the code
// store; each result passes through the push state.
// A result leaves one result behind the search, since run_last is only known
// once the next result or the end of the item is found. After reset the
// accumulator, padding and search count are zero and the table contents are
// undefined until written. While the receiver stalls, the result register
// holds its transaction and the search stops when a further result is ready.
`default_nettype none

module prefix_code_table_decoder_unit (
	input  wire                           clk,
	input  wire                           arst_n,
	input  wire                           item_valid,
	output logic                          item_stall,
	input  pcd_pkg::item_t                item,
	output logic                          result_valid,
	input  wire                           result_stall,
	output pcd_pkg::result_t              result,
	input  wire                           cfg_we,
	input  wire [pcd_pkg::TCOUNT_W-1:0]   cfg_wdata
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_SHIFT,
		S_SCAN,
		S_PUSH,
		S_NEXT,
		S_FINAL
	} state_t;

	state_t                        state_q;
	logic [pcd_pkg::TCOUNT_W-1:0]  search_count_q;
	logic [pcd_pkg::CODE_W-1:0]    code_q;
	logic [pcd_pkg::CNT_W-1:0]     count_q;
	logic [2:0]                    pad_q;
	logic [7:0]                    data_q;
	logic [3:0]                    bits_left_q;
	logic                          last_q;
	logic [pcd_pkg::TCOUNT_W-1:0]  ptr_q;
	logic                          rd_pend_q;
	pcd_pkg::result_t              nxt_q;
	logic                          nxt_final_q;
	pcd_pkg::result_t              hold_q;
	logic                          hold_valid_q;
	pcd_pkg::result_t              result_q;
	logic                          result_valid_q;

	logic                          item_accept;
	logic                          slot_free;
	logic                          result_load;
	logic                          hit_now;
	logic [pcd_pkg::TCOUNT_W-1:0]  n_search;
	pcd_pkg::store_wr_t            store_wr;
	pcd_pkg::store_rd_t            store_rd;
	pcd_pkg::store_hit_t           store_hit;

	assign item_stall   = (state_q != S_IDLE);
	assign item_accept  = item_valid && !item_stall;
	assign slot_free    = !result_valid_q || !result_stall;
	assign result_load  = hold_valid_q && slot_free &&
		((state_q == S_PUSH) || (state_q == S_FINAL));
	assign result_valid = result_valid_q;
	assign result       = result_q;
	assign n_search     = (search_count_q > pcd_pkg::DEPTH_COUNT) ?
		pcd_pkg::DEPTH_COUNT : search_count_q;
	assign hit_now      = rd_pend_q && store_hit.hit;

	always_comb begin
		store_wr.en           = item_accept && (item.kind == pcd_pkg::KIND_ENTRY) &&
			({1'b0, item.entry_index} < pcd_pkg::DEPTH_COUNT);
		store_wr.addr         = item.entry_index[pcd_pkg::ADDR_W-1:0];
		store_wr.entry.code   = item.entry_code;
		store_wr.entry.length = item.entry_length;
		store_wr.entry.symbol = item.entry_symbol;
		store_rd.en           = (state_q == S_SCAN) && !hit_now && (ptr_q < n_search);
		store_rd.addr         = ptr_q[pcd_pkg::ADDR_W-1:0];
	end

	pcd_code_store u_store (
		.clk   (clk),
		.wr    (store_wr),
		.rd    (store_rd),
		.code  (code_q),
		.count (count_q),
		.hit   (store_hit)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			search_count_q <= '0;
			code_q         <= '0;
			count_q        <= '0;
			pad_q          <= '0;
			data_q         <= '0;
			bits_left_q    <= '0;
			last_q         <= 1'b0;
			ptr_q          <= '0;
			rd_pend_q      <= 1'b0;
			nxt_q          <= '0;
			nxt_final_q    <= 1'b0;
			hold_q         <= '0;
			hold_valid_q   <= 1'b0;
			result_q       <= '0;
			result_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				search_count_q <= cfg_wdata;
			end
			if (result_load) begin
				result_valid_q <= 1'b1;
			end else if (result_valid_q && !result_stall) begin
				result_valid_q <= 1'b0;
			end

			unique case (state_q)
				S_IDLE: begin
					if (item_accept) begin
						unique case (item.kind)
							pcd_pkg::KIND_HEADER: begin
								code_q  <= '0;
								count_q <= '0;
								if (item.last_byte) begin
									pad_q               <= '0;
									nxt_q.result_type   <= pcd_pkg::RES_FRAME_END;
									nxt_q.symbol        <= '0;
									nxt_q.leftover_bits <= '0;
									nxt_q.run_last      <= 1'b0;
									nxt_final_q         <= 1'b1;
									state_q             <= S_PUSH;
								end else begin
									pad_q <= (item.data_byte > 8'd7) ?
										pcd_pkg::PAD_MAX : item.data_byte[2:0];
								end
							end
							pcd_pkg::KIND_PAYLOAD: begin
								data_q      <= item.data_byte;
								last_q      <= item.last_byte;
								bits_left_q <= item.last_byte ? (4'd8 - {1'b0, pad_q}) : 4'd8;
								state_q     <= S_SHIFT;
							end
							default: begin
							end
						endcase
					end
				end
				S_SHIFT: begin
					code_q      <= {code_q[pcd_pkg::CODE_W-2:0], data_q[7]};
					data_q      <= {data_q[6:0], 1'b0};
					count_q     <= count_q + 1'b1;
					bits_left_q <= bits_left_q - 1'b1;
					ptr_q       <= '0;
					rd_pend_q   <= 1'b0;
					state_q     <= S_SCAN;
				end
				S_SCAN: begin
					rd_pend_q <= store_rd.en;
					if (store_rd.en) begin
						ptr_q <= ptr_q + 1'b1;
					end
					if (hit_now) begin
						nxt_q.result_type   <= pcd_pkg::RES_SYMBOL;
						nxt_q.symbol        <= store_hit.symbol;
						nxt_q.leftover_bits <= '0;
						nxt_q.run_last      <= 1'b0;
						nxt_final_q         <= 1'b0;
						code_q              <= '0;
						count_q             <= '0;
						state_q             <= S_PUSH;
					end else if (ptr_q >= n_search) begin
						if (count_q >= pcd_pkg::LIMIT_COUNT) begin
							nxt_q.result_type   <= pcd_pkg::RES_OVERFLOW;
							nxt_q.symbol        <= '0;
							nxt_q.leftover_bits <= '0;
							nxt_q.run_last      <= 1'b0;
							nxt_final_q         <= 1'b0;
							code_q              <= '0;
							count_q             <= '0;
							state_q             <= S_PUSH;
						end else begin
							state_q <= S_NEXT;
						end
					end
				end
				S_NEXT: begin
					if (bits_left_q != '0) begin
						state_q <= S_SHIFT;
					end else if (last_q) begin
						nxt_q.result_type   <= pcd_pkg::RES_FRAME_END;
						nxt_q.symbol        <= '0;
						nxt_q.leftover_bits <= count_q;
						nxt_q.run_last      <= 1'b0;
						nxt_final_q         <= 1'b1;
						code_q              <= '0;
						count_q             <= '0;
						pad_q               <= '0;
						state_q             <= S_PUSH;
					end else begin
						state_q <= S_FINAL;
					end
				end
				S_PUSH: begin
					if (!hold_valid_q || slot_free) begin
						if (hold_valid_q) begin
							result_q <= {hold_q.result_type, hold_q.symbol,
								hold_q.leftover_bits, 1'b0};
						end
						hold_q       <= nxt_q;
						hold_valid_q <= 1'b1;
						state_q      <= nxt_final_q ? S_FINAL : S_NEXT;
					end
				end
				S_FINAL: begin
					if (!hold_valid_q) begin
						state_q <= S_IDLE;
					end else if (slot_free) begin
						result_q     <= {hold_q.result_type, hold_q.symbol,
							hold_q.leftover_bits, 1'b1};
						hold_valid_q <= 1'b0;
						state_q      <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= pcd_pkg::LIMIT_COUNT)
		else $error("Accumulated bit count exceeds the code length limit.");

	assert property (@(posedge clk) disable iff (!arst_n)
		!(store_wr.en && store_rd.en))
		else $error("Table write overlaps a table search.");

	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> !hold_valid_q)
		else $error("A held result remains while the block is idle.");

	assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid_q && (result_q.result_type == pcd_pkg::RES_FRAME_END))
		|-> result_q.run_last)
		else $error("A frame-end result is not marked as the last of its item.");

	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FINAL && hold_valid_q && slot_free)
		|=> (result_valid_q && result_q.run_last))
		else $error("The final held result was not delivered with run_last.");

endmodule

`default_nettype wire
